// File: rtl/core/tcct_pkg.sv
package tcct_pkg;

   // default pixel component width (signed Q1.14 at 16 bits)
   localparam int DATA_WIDTH_DEF = 16;

   // fixed formats
   localparam int COEF_W    = 16;                 // offsets and coefficients, Q1.14
   localparam int FRAC      = 14;                 // fraction bits kept after each product
   localparam int TERM_W    = 32;                 // saturated input products
   localparam int CPROD_W   = COEF_W + TERM_W;    // coefficient times term
   localparam int RT_W      = CPROD_W - FRAC;     // rounded coefficient product
   localparam int ACC_W     = RT_W + 4;           // offset plus seven rounded terms
   localparam int OUT_W     = 18;                 // Q3.14 result
   localparam int WIDE_W    = 66;                 // headroom for any input product
   localparam int NUM_CH    = 3;
   localparam int NUM_TERMS = 7;
   localparam int RND_HALF  = 1 << (FRAC - 1);

   // register layout
   localparam int BLK_W      = 52;
   localparam int VTX_W      = 51;
   localparam int KEEP_LSB   = 48;
   localparam int EN_LSB     = 48;
   localparam int BYPASS_BIT = 51;
   localparam logic [BLK_W-1:0] BLK_RESET = BLK_W'(1) << BYPASS_BIT;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_BLACK = CSR_IDX_W'(0);

   // term order inside the vertex registers
   localparam int TERM_X   = 0;
   localparam int TERM_Y   = 1;
   localparam int TERM_Z   = 2;
   localparam int TERM_XY  = 3;
   localparam int TERM_XZ  = 4;
   localparam int TERM_YZ  = 5;
   localparam int TERM_XYZ = 6;

   // result stream packing
   localparam int RSP_TDATA_W = ((NUM_CH * OUT_W + 7) / 8) * 8;
   localparam int RSP_PAD     = RSP_TDATA_W - NUM_CH * OUT_W;

   localparam longint TERM_MAX = (64'sd1 <<< (TERM_W - 1)) - 64'sd1;
   localparam longint TERM_MIN = -(64'sd1 <<< (TERM_W - 1));
   localparam int     OUT_MAX  = (1 << (OUT_W - 1)) - 1;
   localparam int     OUT_MIN  = -(1 << (OUT_W - 1));

   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [TERM_W-1:0]  term_type;
   typedef logic signed [CPROD_W-1:0] cprod_type;
   typedef logic signed [RT_W-1:0]    rterm_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [OUT_W-1:0]   out_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   // one coefficient (or offset) out of a vertex register
   function automatic coef_type coef_of(input logic [VTX_W-1:0] v, input logic [1:0] sel);
      coef_type r;
      r = v[COEF_W*sel +: COEF_W];
      return r;
   endfunction

   // round half up to FRAC fraction bits, then clamp to the term range
   function automatic term_type rnd_sat_term(input wide_type p);
      wide_type r;
      term_type t;
      r = (p + wide_type'(RND_HALF)) >>> FRAC;
      if (r > wide_type'(TERM_MAX)) begin
         t = term_type'(TERM_MAX);
      end else if (r < wide_type'(TERM_MIN)) begin
         t = term_type'(TERM_MIN);
      end else begin
         t = term_type'(r);
      end
      return t;
   endfunction

   // round half up a coefficient product, never exceeds RT_W bits
   function automatic rterm_type rnd_coef(input cprod_type p);
      logic signed [CPROD_W:0] r;
      r = ((CPROD_W + 1)'(p) + (CPROD_W + 1)'(RND_HALF)) >>> FRAC;
      return rterm_type'(r);
   endfunction

endpackage

// File: rtl/core/trilinear_color_cube_transform_core.sv
// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  tdata: in_x, in_y, in_z (DATA_WIDTH each)
// rsp      out        rsp_tvalid/rsp_tready  tdata: out_x, out_y, out_z (18 each)
//                                            tuser: clipped
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// one pixel per cycle unless rsp or csr stalls; seven register stages from req to rsp_tvalid
// depth is set by the chain of three multiplies: x*y, then (x*y)*z, then coefficient times xyz
// each stage holds its own valid bit and loads when the next one is free, so bubbles close up
// and a stalled rsp backs up stage by stage without losing or repeating a pixel
// a csr write waits for an empty pipe and holds off req transfers while it waits
// synchronous reset empties the pipe and loads bypass on, all coefficients zero
module trilinear_color_cube_transform_core #(
   parameter int DATA_WIDTH = tcct_pkg::DATA_WIDTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // req stream
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // in_x, in_y, in_z from bit 0 up, zero padded to whole bytes
   input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]         req_tdata,
   // rsp stream
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // out_x, out_y, out_z from bit 0 up, zero padded to whole bytes
   output logic [tcct_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   // clipped
   output logic                                      rsp_tuser,
   // configuration writes
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [tcct_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [tcct_pkg::BLK_W-1:0]                csr_data
);
   import tcct_pkg::*;

   localparam int NSTG = 7;

   typedef logic signed [DATA_WIDTH-1:0]          pix_type;
   typedef logic signed [2*DATA_WIDTH-1:0]        sq_type;
   typedef logic signed [TERM_W+DATA_WIDTH-1:0]   trip_type;

   // configuration registers
   logic [BLK_W-1:0] blk_ff, blk_in;
   logic [VTX_W-1:0] vtx_ff [NUM_TERMS];
   logic [VTX_W-1:0] vtx_in [NUM_TERMS];
   logic             bypass;

   // pipeline control
   logic [NSTG:1] vld_ff, vld_in;
   logic [NSTG:1] adv;

   // stage payloads
   pix_type   s1_pix_ff [NUM_CH], s1_pix_in [NUM_CH];

   pix_type   s2_pix_ff [NUM_CH];
   sq_type    s2_sq_ff  [3], s2_sq_in [3];
   cprod_type s2_lp_ff  [3][NUM_CH], s2_lp_in [3][NUM_CH];

   pix_type   s3_pix_ff [NUM_CH];
   term_type  s3_t_ff   [3], s3_t_in [3];
   rterm_type s3_lr_ff  [3][NUM_CH], s3_lr_in [3][NUM_CH];

   pix_type   s4_pix_ff [NUM_CH];
   trip_type  s4_pxyz_ff, s4_pxyz_in;
   cprod_type s4_qp_ff  [3][NUM_CH], s4_qp_in [3][NUM_CH];
   acc_type   s4_acc_ff [NUM_CH], s4_acc_in [NUM_CH];

   pix_type   s5_pix_ff [NUM_CH];
   term_type  s5_txyz_ff, s5_txyz_in;
   acc_type   s5_acc_ff [NUM_CH], s5_acc_in [NUM_CH];

   pix_type   s6_pix_ff [NUM_CH];
   cprod_type s6_cp_ff  [NUM_CH], s6_cp_in [NUM_CH];
   acc_type   s6_acc_ff [NUM_CH];

   out_type   out_ff [NUM_CH], out_in [NUM_CH];
   logic      clip_ff, clip_in;

   assign bypass = blk_ff[BYPASS_BIT];

   // configuration write decode, every index maps to a register
   // writes only land on an empty pipe so no pixel mixes old and new settings
   assign csr_ready = ~|vld_ff;

   always_comb begin
      blk_in = blk_ff;
      for (int k = 0; k < NUM_TERMS; k++) begin
         vtx_in[k] = vtx_ff[k];
      end
      if (csr_valid && csr_ready) begin
         if (csr_index == REG_BLACK) begin
            blk_in = csr_data;
         end else begin
            vtx_in[csr_index - CSR_IDX_W'(1)] = csr_data[VTX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff <= BLK_RESET;
         for (int k = 0; k < NUM_TERMS; k++) begin
            vtx_ff[k] <= '0;
         end
      end else begin
         blk_ff <= blk_in;
         for (int k = 0; k < NUM_TERMS; k++) begin
            vtx_ff[k] <= vtx_in[k];
         end
      end
   end

   // stage advance: a stage loads when it is empty or its successor loads
   always_comb begin
      adv[NSTG] = !vld_ff[NSTG] || rsp_tready;
      for (int i = NSTG - 1; i >= 1; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in = vld_ff;
      if (adv[1]) begin
         vld_in[1] = req_tvalid && !csr_valid;
      end
      for (int i = 2; i <= NSTG; i++) begin
         if (adv[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = adv[1] && !csr_valid;
   assign rsp_tvalid = vld_ff[NSTG];

   // stage 1: unpack, apply keep bits unless bypassed
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         if (bypass || blk_ff[KEEP_LSB + c]) begin
            s1_pix_in[c] = req_tdata[DATA_WIDTH*c +: DATA_WIDTH];
         end else begin
            s1_pix_in[c] = '0;
         end
      end
   end

   // stage 2: pairwise input products and linear coefficient products
   always_comb begin
      s2_sq_in[0] = s1_pix_ff[0] * s1_pix_ff[1];
      s2_sq_in[1] = s1_pix_ff[0] * s1_pix_ff[2];
      s2_sq_in[2] = s1_pix_ff[1] * s1_pix_ff[2];
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < NUM_CH; c++) begin
            s2_lp_in[k][c] = coef_of(vtx_ff[TERM_X + k], 2'(c)) * term_type'(s1_pix_ff[k]);
         end
      end
   end

   // stage 3: round and clamp the pair terms, round the linear terms
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s3_t_in[k] = rnd_sat_term(wide_type'(s2_sq_ff[k]));
         for (int c = 0; c < NUM_CH; c++) begin
            s3_lr_in[k][c] = rnd_coef(s2_lp_ff[k][c]);
         end
      end
   end

   // stage 4: triple product, pair coefficient products, offset plus linear sum
   always_comb begin
      s4_pxyz_in = s3_t_ff[0] * s3_pix_ff[2];
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < NUM_CH; c++) begin
            s4_qp_in[k][c] = coef_of(vtx_ff[TERM_XY + k], 2'(c)) * s3_t_ff[k];
         end
      end
      for (int c = 0; c < NUM_CH; c++) begin
         s4_acc_in[c] = acc_type'(coef_of(blk_ff[VTX_W-1:0], 2'(c)));
         for (int k = 0; k < 3; k++) begin
            if (vtx_ff[TERM_X + k][EN_LSB + c]) begin
               s4_acc_in[c] = s4_acc_in[c] + acc_type'(s3_lr_ff[k][c]);
            end
         end
      end
   end

   // stage 5: round and clamp the triple term, add the pair terms
   always_comb begin
      s5_txyz_in = rnd_sat_term(wide_type'(s4_pxyz_ff));
      for (int c = 0; c < NUM_CH; c++) begin
         s5_acc_in[c] = s4_acc_ff[c];
         for (int k = 0; k < 3; k++) begin
            if (vtx_ff[TERM_XY + k][EN_LSB + c]) begin
               s5_acc_in[c] = s5_acc_in[c] + acc_type'(rnd_coef(s4_qp_ff[k][c]));
            end
         end
      end
   end

   // stage 6: coefficient times triple term
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         s6_cp_in[c] = coef_of(vtx_ff[TERM_XYZ], 2'(c)) * s5_txyz_ff;
      end
   end

   // stage 7: last term, bypass select, saturate to the output range
   always_comb begin
      acc_type sum;
      clip_in = 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
         if (bypass) begin
            sum = acc_type'(s6_pix_ff[c]);
         end else if (vtx_ff[TERM_XYZ][EN_LSB + c]) begin
            sum = s6_acc_ff[c] + acc_type'(rnd_coef(s6_cp_ff[c]));
         end else begin
            sum = s6_acc_ff[c];
         end
         if (sum > acc_type'(OUT_MAX)) begin
            out_in[c] = out_type'(OUT_MAX);
            clip_in   = 1'b1;
         end else if (sum < acc_type'(OUT_MIN)) begin
            out_in[c] = out_type'(OUT_MIN);
            clip_in   = 1'b1;
         end else begin
            out_in[c] = out_type'(sum);
         end
      end
   end

   // payload registers, each loads with its stage
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_pix_ff <= s1_pix_in;
      end
      if (adv[2]) begin
         s2_pix_ff <= s1_pix_ff;
         s2_sq_ff  <= s2_sq_in;
         s2_lp_ff  <= s2_lp_in;
      end
      if (adv[3]) begin
         s3_pix_ff <= s2_pix_ff;
         s3_t_ff   <= s3_t_in;
         s3_lr_ff  <= s3_lr_in;
      end
      if (adv[4]) begin
         s4_pix_ff  <= s3_pix_ff;
         s4_pxyz_ff <= s4_pxyz_in;
         s4_qp_ff   <= s4_qp_in;
         s4_acc_ff  <= s4_acc_in;
      end
      if (adv[5]) begin
         s5_pix_ff  <= s4_pix_ff;
         s5_txyz_ff <= s5_txyz_in;
         s5_acc_ff  <= s5_acc_in;
      end
      if (adv[6]) begin
         s6_pix_ff <= s5_pix_ff;
         s6_cp_ff  <= s6_cp_in;
         s6_acc_ff <= s5_acc_ff;
      end
      if (adv[7]) begin
         out_ff  <= out_in;
         clip_ff <= clip_in;
      end
   end

   // result packing
   assign rsp_tdata = {{RSP_PAD{1'b0}}, out_ff[2], out_ff[1], out_ff[0]};
   assign rsp_tuser = clip_ff;

endmodule

// File: verif/tb_trilinear_color_cube_transform_core.sv
`timescale 1ns / 1ps

module tb_trilinear_color_cube_transform_core;

   localparam int DW          = tcct_pkg::DATA_WIDTH_DEF;
   localparam int REQ_W       = ((3 * DW + 7) / 8) * 8;
   localparam int OW          = tcct_pkg::OUT_W;
   localparam int CW          = tcct_pkg::COEF_W;
   localparam int IDX_W       = tcct_pkg::CSR_IDX_W;
   localparam int BW          = tcct_pkg::BLK_W;
   localparam int HOLD_CYCLES = 300;
   localparam int PIX_PER_RUN = 100;
   localparam int NUM_RUNS    = 12;
   localparam int MAX_REPORTS = 10;

   // vertex register indexes, black is taken from the package
   localparam logic [IDX_W-1:0] REG_RED     = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_GREEN   = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_BLUE    = IDX_W'(3);
   localparam logic [IDX_W-1:0] REG_YELLOW  = IDX_W'(4);
   localparam logic [IDX_W-1:0] REG_MAGENTA = IDX_W'(5);
   localparam logic [IDX_W-1:0] REG_CYAN    = IDX_W'(6);
   localparam logic [IDX_W-1:0] REG_WHITE   = IDX_W'(7);

   localparam logic [DW-1:0] PIX_MAX = {1'b0, {(DW - 1){1'b1}}};
   localparam logic [DW-1:0] PIX_MIN = {1'b1, {(DW - 1){1'b0}}};
   localparam logic [CW-1:0] COEF_MAX = 16'h7FFF;
   localparam logic [CW-1:0] COEF_MIN = 16'h8000;
   localparam logic [CW-1:0] COEF_ONE = 16'h4000;

   typedef struct packed {
      logic [OW-1:0] ch_x;
      logic [OW-1:0] ch_y;
      logic [OW-1:0] ch_z;
      logic          clipped;
   } color_result_t;

   // scoreboard: own copy of the cube registers and the queue of predicted pixels
   class color_cube_scoreboard;
      logic [BW-1:0] cube_regs [8];
      color_result_t predicted_q [$];
      int unsigned   n_mismatch;

      function new();
         foreach (cube_regs[i]) cube_regs[i] = '0;
         cube_regs[tcct_pkg::REG_BLACK] = tcct_pkg::BLK_RESET;
         n_mismatch = 0;
      endfunction

      function void write_csr(logic [IDX_W-1:0] idx, logic [BW-1:0] val);
         if (idx == tcct_pkg::REG_BLACK) begin
            cube_regs[idx] = val;
         end else begin
            cube_regs[idx] = val & {1'b0, {tcct_pkg::VTX_W{1'b1}}};
         end
      endfunction

      // round half up to 14 fraction bits
      function longint round_q14(longint p);
         return (p + longint'(tcct_pkg::RND_HALF)) >>> tcct_pkg::FRAC;
      endfunction

      function longint limit(longint v, longint lo, longint hi, inout bit sat);
         if (v > hi) begin
            sat = 1'b1;
            return hi;
         end
         if (v < lo) begin
            sat = 1'b1;
            return lo;
         end
         return v;
      endfunction

      function color_result_t transform(logic [REQ_W-1:0] pix);
         longint        chan [3];
         longint        term [7];
         longint        acc [3];
         longint        coef;
         bit            sat;
         bit            term_sat;
         logic [BW-1:0] blk;
         color_result_t r;
         blk      = cube_regs[tcct_pkg::REG_BLACK];
         sat      = 1'b0;
         term_sat = 1'b0;
         for (int c = 0; c < 3; c++) chan[c] = $signed(pix[DW*c +: DW]);
         if (blk[tcct_pkg::BYPASS_BIT]) begin
            for (int c = 0; c < 3; c++) acc[c] = chan[c];
         end else begin
            // keep bits zero whole input channels
            for (int c = 0; c < 3; c++) begin
               if (!blk[tcct_pkg::KEEP_LSB + c]) chan[c] = 0;
               term[c] = chan[c];
            end
            term[tcct_pkg::TERM_XY] = limit(round_q14(chan[0] * chan[1]),
               tcct_pkg::TERM_MIN, tcct_pkg::TERM_MAX, term_sat);
            term[tcct_pkg::TERM_XZ] = limit(round_q14(chan[0] * chan[2]),
               tcct_pkg::TERM_MIN, tcct_pkg::TERM_MAX, term_sat);
            term[tcct_pkg::TERM_YZ] = limit(round_q14(chan[1] * chan[2]),
               tcct_pkg::TERM_MIN, tcct_pkg::TERM_MAX, term_sat);
            // xyz builds on the already rounded xy
            term[tcct_pkg::TERM_XYZ] = limit(round_q14(term[tcct_pkg::TERM_XY] * chan[2]),
               tcct_pkg::TERM_MIN, tcct_pkg::TERM_MAX, term_sat);
            for (int c = 0; c < 3; c++) acc[c] = $signed(blk[CW*c +: CW]);
            // enabled coefficient terms per output channel
            for (int k = 0; k < tcct_pkg::NUM_TERMS; k++) begin
               for (int c = 0; c < 3; c++) begin
                  if (cube_regs[k+1][tcct_pkg::EN_LSB + c]) begin
                     coef   = $signed(cube_regs[k+1][CW*c +: CW]);
                     acc[c] += round_q14(coef * term[k]);
                  end
               end
            end
         end
         for (int c = 0; c < 3; c++) begin
            acc[c] = limit(acc[c], longint'(tcct_pkg::OUT_MIN), longint'(tcct_pkg::OUT_MAX), sat);
         end
         r.ch_x    = acc[0][OW-1:0];
         r.ch_y    = acc[1][OW-1:0];
         r.ch_z    = acc[2][OW-1:0];
         r.clipped = sat;
         return r;
      endfunction

      function void note_pixel(logic [REQ_W-1:0] pix);
         predicted_q.push_back(transform(pix));
      endfunction

      function void check_result(logic [tcct_pkg::RSP_TDATA_W-1:0] data, logic flag);
         color_result_t want;
         color_result_t got;
         got.ch_x    = data[0 +: OW];
         got.ch_y    = data[OW +: OW];
         got.ch_z    = data[2*OW +: OW];
         got.clipped = flag;
         if (predicted_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS) begin
               $display("[%0t] unexpected pixel x=%0d y=%0d z=%0d clipped=%0b", $realtime,
                  $signed(got.ch_x), $signed(got.ch_y), $signed(got.ch_z), got.clipped);
            end
            return;
         end
         want = predicted_q.pop_front();
         if (got.ch_x !== want.ch_x || got.ch_y !== want.ch_y ||
             got.ch_z !== want.ch_z || got.clipped !== want.clipped) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS) begin
               $display("[%0t] pixel mismatch exp x=%0d y=%0d z=%0d clipped=%0b", $realtime,
                  $signed(want.ch_x), $signed(want.ch_y), $signed(want.ch_z), want.clipped);
               $display("          got x=%0d y=%0d z=%0d clipped=%0b",
                  $signed(got.ch_x), $signed(got.ch_y), $signed(got.ch_z), got.clipped);
            end
         end
      endfunction

      function int pending();
         return predicted_q.size();
      endfunction
   endclass

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // in_x, in_y, in_z
   logic [REQ_W-1:0]                 req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // out_x, out_y, out_z, zero pad
   logic [tcct_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   // clipped
   logic                             rsp_tuser;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [IDX_W-1:0]                 csr_index  = '0;
   logic [BW-1:0]                    csr_data   = '0;

   bit idling_on = 1'b1;
   bit hold_off  = 1'b0;

   color_cube_scoreboard sb;

   always #5 clock = ~clock;

   trilinear_color_cube_transform_core #(
      .DATA_WIDTH(DW)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // watch every transfer on the three channels
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) sb.write_csr(csr_index, csr_data);
      if (!reset && req_tvalid && req_tready) sb.note_pixel(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // result side backpressure: random stalls and one long hold
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
            rsp_tready <= 1'b1;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_pixel(input logic [DW-1:0] x, input logic [DW-1:0] y,
                             input logic [DW-1:0] z);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({z, y, x});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [BW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // black vertex plus the same value in all seven coefficient vertices
   task automatic load_uniform(input logic [BW-1:0] black, input logic [BW-1:0] vertex);
      write_reg(tcct_pkg::REG_BLACK, black);
      for (int k = REG_RED; k <= REG_WHITE; k++) write_reg(IDX_W'(k), vertex);
   endtask

   function automatic logic [CW-1:0] rand_coef();
      logic [CW-1:0] v;
      case ($urandom_range(0, 5))
         0: v = COEF_MAX;
         1: v = COEF_MIN;
         2: v = '0;
         3, 4: v = CW'($urandom_range(0, 8191)) - CW'(4096);
         default: v = CW'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [DW-1:0] rand_sample();
      logic [DW-1:0] v;
      case ($urandom_range(0, 7))
         0: v = PIX_MAX;
         1: v = PIX_MIN;
         2: v = $urandom_range(0, 1) ? '0 : '1;
         3, 4: v = DW'($urandom_range(0, 16383)) - DW'(8192);
         default: v = DW'($urandom);
      endcase
      return v;
   endfunction

   // bit 51 of a coefficient vertex lies past its width and is left random
   function automatic logic [BW-1:0] rand_vertex();
      return {1'($urandom), 3'($urandom), rand_coef(), rand_coef(), rand_coef()};
   endfunction

   function automatic logic [BW-1:0] rand_black();
      logic       bypass;
      logic [2:0] keep;
      bypass = ($urandom_range(0, 7) == 0);
      keep   = ($urandom_range(0, 2) == 0) ? 3'($urandom) : 3'b111;
      return {bypass, keep, rand_coef(), rand_coef(), rand_coef()};
   endfunction

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state is bypass
      send_pixel('0, '0, '0);
      send_pixel(PIX_MAX, PIX_MIN, DW'(1));
      send_pixel('1, PIX_MIN, PIX_MAX);
      send_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
      wait_drained();

      // every offset and coefficient at the positive extreme, all terms on
      load_uniform({1'b0, 3'b111, {3{COEF_MAX}}}, {1'b1, 3'b111, {3{COEF_MAX}}});
      send_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
      send_pixel(PIX_MIN, PIX_MIN, PIX_MIN);
      send_pixel(PIX_MIN, PIX_MAX, PIX_MIN);
      send_pixel('0, '0, '0);
      wait_drained();

      // negative extreme everywhere
      load_uniform({1'b0, 3'b111, {3{COEF_MIN}}}, {1'b0, 3'b111, {3{COEF_MIN}}});
      send_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
      send_pixel(PIX_MIN, PIX_MIN, PIX_MIN);
      send_pixel(PIX_MIN, PIX_MAX, PIX_MIN);
      send_pixel('0, '0, '0);
      wait_drained();

      // only y kept, unit coefficients: every product with x or z drops out
      load_uniform({1'b0, 3'b010, {3{CW'(0)}}}, {1'b0, 3'b111, {3{COEF_ONE}}});
      send_pixel(PIX_MAX, PIX_MIN, DW'(16'h1234));
      send_pixel(PIX_MIN, PIX_MAX, '1);
      send_pixel(DW'(16'h2000), DW'(16'hC000), DW'(16'h4000));
      wait_drained();

      // bypass wins over keep bits and coefficients
      write_reg(tcct_pkg::REG_BLACK, {1'b1, 3'b000, {3{CW'(16'h1234)}}});
      send_pixel(PIX_MIN, PIX_MAX, DW'(16'h5A5A));
      send_pixel(DW'(16'hA5A5), '0, PIX_MIN);
      wait_drained();

      // random settings, each followed by a run of random pixels
      for (int run = 0; run < NUM_RUNS; run++) begin
         idling_on = (run < NUM_RUNS - 2) && (run % 4 != 2);
         write_reg(tcct_pkg::REG_BLACK, rand_black());
         for (int k = REG_RED; k <= REG_WHITE; k++) write_reg(IDX_W'(k), rand_vertex());
         if (run == 3) hold_off = 1'b1;
         repeat (PIX_PER_RUN) send_pixel(rand_sample(), rand_sample(), rand_sample());
         wait_drained();
      end

      if (sb.n_mismatch == 0 && sb.pending() == 0) begin
         $display("** trilinear_color_cube_transform_core: PASSED **");
      end else begin
         $display("** trilinear_color_cube_transform_core: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("** trilinear_color_cube_transform_core: FAILED **");
      $finish;
   end

endmodule
